FILE: rtl/fbc_pkg.sv
// shared constants and types for the frustum box cull block
// no dependencies; imported by fbc_plane_eval and frustum_box_cull
package fbc_pkg;

  // plane register layout: A, B, C in Q1.10, D in 2^-10 units
  localparam int PLANE_W   = 64;
  localparam int COEF_W    = 12;
  localparam int OFS_W     = 28;
  localparam int A_LSB     = 0;
  localparam int B_LSB     = 12;
  localparam int C_LSB     = 24;
  localparam int D_LSB     = 36;

  // six plane registers: near, far, left, right, top, bottom
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W    = 6;
  localparam int CORNERS   = 8;

  localparam int NUM_PLANES_DEF = 6;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [1:0] CLASS_INSIDE  = 2'd0;
  localparam logic [1:0] CLASS_PARTIAL = 2'd1;
  localparam logic [1:0] CLASS_OUTSIDE = 2'd2;

  // load enables of the three arithmetic stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } fbc_stage_en_t;

endpackage

FILE: rtl/fbc_plane_eval.sv
// three-stage test of the eight box corners against one plane
// depends on fbc_pkg; instantiated once per active plane by frustum_box_cull
module fbc_plane_eval #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  fbc_pkg::fbc_stage_en_t        en_i,
  input  logic [fbc_pkg::PLANE_W-1:0]   plane_i,
  input  logic signed [COORD_BITS-1:0]  min_x_i,
  input  logic signed [COORD_BITS-1:0]  min_y_i,
  input  logic signed [COORD_BITS-1:0]  min_z_i,
  input  logic signed [COORD_BITS-1:0]  max_x_i,
  input  logic signed [COORD_BITS-1:0]  max_y_i,
  input  logic signed [COORD_BITS-1:0]  max_z_i,
  output logic [fbc_pkg::CORNERS-1:0]   code_o
);
  import fbc_pkg::*;

  localparam int PROD_W = COORD_BITS + COEF_W;
  localparam int AB_W   = PROD_W + 1;
  localparam int CD_W   = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 1;
  localparam int SUM_W  = ((AB_W > CD_W) ? AB_W : CD_W) + 1;

  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;

  // stage 1: the six products and the offset
  logic signed [1:0][PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [1:0][PROD_W-1:0] px_d, py_d, pz_d;
  logic signed [OFS_W-1:0]       ofs_q;

  // stage 2: x+y sums for four corner pairs, z+d sums for two
  logic signed [3:0][AB_W-1:0] ab_q, ab_d;
  logic signed [1:0][CD_W-1:0] cd_q, cd_d;

  // stage 3: per-corner outside bits
  logic [CORNERS-1:0] code_q, code_d;

  assign coef_a = plane_i[A_LSB +: COEF_W];
  assign coef_b = plane_i[B_LSB +: COEF_W];
  assign coef_c = plane_i[C_LSB +: COEF_W];

  always_comb begin
    px_d[0] = PROD_W'($signed(coef_a) * $signed(min_x_i));
    px_d[1] = PROD_W'($signed(coef_a) * $signed(max_x_i));
    py_d[0] = PROD_W'($signed(coef_b) * $signed(min_y_i));
    py_d[1] = PROD_W'($signed(coef_b) * $signed(max_y_i));
    pz_d[0] = PROD_W'($signed(coef_c) * $signed(min_z_i));
    pz_d[1] = PROD_W'($signed(coef_c) * $signed(max_z_i));
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ab_d[k] = AB_W'($signed(px_q[k % 2])) + AB_W'($signed(py_q[k / 2]));
    end
    for (int j = 0; j < 2; j++) begin
      cd_d[j] = CD_W'($signed(pz_q[j])) + CD_W'($signed(ofs_q));
    end
  end

  // corner k takes x from bit 0, y from bit 1, z from bit 2
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int k = 0; k < CORNERS; k++) begin
      sum = SUM_W'($signed(ab_q[k % 4])) + SUM_W'($signed(cd_q[k / 4]));
      code_d[k] = (sum > SUM_W'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      ofs_q <= plane_i[D_LSB +: OFS_W];
    end
    if (en_i.en2) begin
      ab_q <= ab_d;
      cd_q <= cd_d;
    end
    if (en_i.en3) begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

FILE: rtl/frustum_box_cull.sv
// top level of the frustum box cull: plane registers, valid pipeline, mask reduction
// depends on fbc_pkg and fbc_plane_eval
//
//  channel | signals                                   | direction | notes
//  --------+-------------------------------------------+-----------+---------------------
//  in      | in_valid_i, in_stall_o, min_*_i, max_*_i  | to block  | one box per request
//  out     | out_valid_o, out_stall_i, result/masks    | from block| one result per box
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data| to block  | plane writes, always ready
//
// one box per cycle sustained while out_stall_i is low; an accepted box passes through
// multiply, pair sums, corner sum and compare, mask reduction into the output register
// reset clears the plane registers to zero and empties every pipeline stage
// an output stall holds the output register; bubbles in earlier stages still close up,
// and in_stall_o rises only once every stage holds a request
module frustum_box_cull #(
  parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF,
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbc_pkg::PLANE_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_BITS-1:0]    min_x_i,
  input  logic signed [COORD_BITS-1:0]    min_y_i,
  input  logic signed [COORD_BITS-1:0]    min_z_i,
  input  logic signed [COORD_BITS-1:0]    max_x_i,
  input  logic signed [COORD_BITS-1:0]    max_y_i,
  input  logic signed [COORD_BITS-1:0]    max_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      result_class_o,
  output logic [fbc_pkg::MASK_W-1:0]      outside_any_mask_o,
  output logic [fbc_pkg::MASK_W-1:0]      outside_all_mask_o
);
  import fbc_pkg::*;

  // planes beyond the six registers are never tested
  localparam int ACTIVE = (NUM_PLANES > NUM_REGS) ? NUM_REGS : NUM_PLANES;

  logic [NUM_REGS-1:0][PLANE_W-1:0] plane_q;

  logic          v1_q, v2_q, v3_q, out_valid_q;
  logic          en_out;
  fbc_stage_en_t stage_en;

  logic [NUM_REGS-1:0][CORNERS-1:0] code;
  logic [MASK_W-1:0]                any_d, all_d, any_q, all_q;
  logic [1:0]                       class_d, class_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (cfg_index_i == CFG_IDX_W'(r)) begin
          plane_q[r] <= cfg_data_i;
        end
      end
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  assign en_out       = !out_valid_q || !out_stall_i;
  assign stage_en.en3 = !v3_q || en_out;
  assign stage_en.en2 = !v2_q || stage_en.en3;
  assign stage_en.en1 = !v1_q || stage_en.en2;
  assign in_stall_o   = !stage_en.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (stage_en.en1) begin
        v1_q <= in_valid_i;
      end
      if (stage_en.en2) begin
        v2_q <= v1_q;
      end
      if (stage_en.en3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  for (genvar p = 0; p < NUM_REGS; p++) begin : g_plane
    if (p < ACTIVE) begin : g_on
      fbc_plane_eval #(
        .COORD_BITS(COORD_BITS)
      ) u_eval (
        .clk_i  (clk_i),
        .en_i   (stage_en),
        .plane_i(plane_q[p]),
        .min_x_i(min_x_i),
        .min_y_i(min_y_i),
        .min_z_i(min_z_i),
        .max_x_i(max_x_i),
        .max_y_i(max_y_i),
        .max_z_i(max_z_i),
        .code_o (code[p])
      );
    end else begin : g_off
      assign code[p] = '0;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_REGS; p++) begin
      any_d[p] = |code[p];
      all_d[p] = &code[p];
    end
    if (any_d == '0) begin
      class_d = CLASS_INSIDE;
    end else if (all_d != '0) begin
      class_d = CLASS_OUTSIDE;
    end else begin
      class_d = CLASS_PARTIAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      any_q   <= any_d;
      all_q   <= all_d;
      class_q <= class_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_class_o     = class_q;
  assign outside_any_mask_o = any_q;
  assign outside_all_mask_o = all_q;

  // a plane that sees every corner outside must also be in the any mask
  a_all_within_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((all_q & ~any_q) == '0))
    else $error("all mask has a plane missing from the any mask");

  a_class_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((class_q == CLASS_INSIDE) == (any_q == '0)))
    else $error("inside class disagrees with any mask");

  a_class_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((class_q == CLASS_OUTSIDE) == (all_q != '0)))
    else $error("outside class disagrees with all mask");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while the pipeline is full and stalled");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && out_stall_i) |=> (v1_q && v2_q && v3_q))
    else $error("pipeline lost a request during a stall");

endmodule
